@@ sv/lkvc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Beat payloads, command codes, register reset value and the control
// bundle that the top level broadcasts to the row of entry cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_W-1:0] MISS_DATA = 32'hFFFF_FFFF;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic command;
		logic signed [KEY_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} lkvc_in_t;

	typedef struct packed {
		logic hit;
		logic signed [DATA_W-1:0] read_data;
	} lkvc_out_t;

	typedef struct packed {
		logic match_en;
		logic upd_en;
		logic command;
		logic hit;
		logic use_free;
	} lkvc_ctl_t;

endpackage
`default_nettype wire

@@ sv/lkvc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the LRU key-value cache
// Holds a key, a value, a valid bit and a recency rank. Matches the broadcast
// key, and passes the free-slot search, the hit data and the hit rank on to
// its neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell #(
	parameter int RANK_W = 4,
	parameter int OCC_W = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lkvc_pkg::lkvc_ctl_t ctl,
	input wire logic [lkvc_pkg::KEY_W-1:0] key,
	input wire logic [lkvc_pkg::DATA_W-1:0] value,
	input wire logic [RANK_W-1:0] hit_rank,
	input wire logic [OCC_W-1:0] occ_m1,
	input wire logic free_in,
	output logic free_out,
	input wire logic hit_in,
	output logic hit_out,
	input wire logic [lkvc_pkg::DATA_W-1:0] data_in,
	output logic [lkvc_pkg::DATA_W-1:0] data_out,
	input wire logic [RANK_W-1:0] rank_in,
	output logic [RANK_W-1:0] rank_out
);

	logic [lkvc_pkg::KEY_W-1:0] key_q;
	logic [lkvc_pkg::DATA_W-1:0] value_q;
	logic valid_q;
	logic [RANK_W-1:0] rank_q;
	logic match_s1;

	logic match_now;
	logic first_free;
	logic lru;
	logic target;
	logic is_put;

	assign match_now = valid_q && (key_q == key);
	assign first_free = !valid_q && !free_in;
	assign lru = valid_q && (OCC_W'(rank_q) == occ_m1);
	assign target = ctl.hit ? match_s1 : (ctl.use_free ? first_free : lru);
	assign is_put = (ctl.command == lkvc_pkg::CMD_PUT);

	assign free_out = free_in || !valid_q;
	assign hit_out = hit_in || match_s1;
	assign data_out = data_in | (match_s1 ? value_q : '0);
	assign rank_out = rank_in | (match_s1 ? rank_q : '0);

	always_ff @(posedge clk) begin
		if (ctl.upd_en && is_put && target) begin
			value_q <= value;
			if (!ctl.hit) begin
				key_q <= key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q <= '0;
			match_s1 <= 1'b0;
		end else begin
			if (ctl.match_en) begin
				match_s1 <= match_now;
			end
			if (ctl.upd_en) begin
				if (ctl.hit) begin
					if (match_s1) begin
						rank_q <= '0;
					end else if (valid_q && (rank_q < hit_rank)) begin
						rank_q <= RANK_W'(rank_q + 1'b1);
					end
				end else if (is_put) begin
					if (target) begin
						valid_q <= 1'b1;
						rank_q <= '0;
					end else if (valid_q) begin
						rank_q <= RANK_W'(rank_q + 1'b1);
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/lru_key_value_cache.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// A row of entry cells compares a key in parallel and keeps recency ranks.
// ----------------------------------------------------------------------------
// Usage: a beat on the input channel carries a command (get or put), a key
// and a value. Every input beat produces exactly one output beat with a hit
// flag and read data: the stored value on a get hit, all ones on a get miss
// and zero for a put.
// Timing: after a beat is accepted the cells compare the key in the next
// cycle (S_MATCH); the entry row is updated in S_UPDATE, when the result is
// loaded into the output register, which can wait on a stall. The input
// channel takes no new beat until the previous one has left S_UPDATE.
// A finished result may wait in the output register while the next beat is
// accepted and compared.
// Stall: while the output register holds an untaken result, the update of
// the next beat waits and the input channel stays stalled.
// Reset: all entries are invalid, the capacity register returns to 16, and
// no beat is pending. The user must write the capacity register through
// cfg_we and cfg_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [lkvc_pkg::CAP_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire lkvc_pkg::lkvc_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output lkvc_pkg::lkvc_out_t out_data
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MATCH = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t state_q;
	lkvc_pkg::lkvc_in_t item_q;
	lkvc_pkg::lkvc_out_t out_q;
	logic out_valid_q;
	logic [lkvc_pkg::CAP_W-1:0] capacity_q;
	logic [OCC_W-1:0] occ_q;

	lkvc_pkg::lkvc_ctl_t ctl;
	logic in_take;
	logic upd_go;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] eff_cap;
	logic use_free;
	logic hit;
	logic [RANK_W-1:0] hit_rank;
	logic [lkvc_pkg::DATA_W-1:0] hit_data;
	logic [lkvc_pkg::DATA_W-1:0] read_data;
	logic [OCC_W-1:0] occ_m1;

	logic free_chain [ENTRIES+1];
	logic hit_chain [ENTRIES+1];
	logic [lkvc_pkg::DATA_W-1:0] data_chain [ENTRIES+1];
	logic [RANK_W-1:0] rank_chain [ENTRIES+1];

	assign in_stall = (state_q != S_IDLE);
	assign in_take = in_valid && !in_stall;
	assign upd_go = (state_q == S_UPDATE) && (!out_valid_q || !out_stall);

	assign cap_ext = CMP_W'(capacity_q);
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end
	assign use_free = CMP_W'(occ_q) < eff_cap;
	assign occ_m1 = OCC_W'(occ_q - 1'b1);

	assign free_chain[0] = 1'b0;
	assign hit_chain[0] = 1'b0;
	assign data_chain[0] = '0;
	assign rank_chain[0] = '0;
	assign hit = hit_chain[ENTRIES];
	assign hit_data = data_chain[ENTRIES];
	assign hit_rank = rank_chain[ENTRIES];

	assign ctl.match_en = (state_q == S_MATCH);
	assign ctl.upd_en = upd_go;
	assign ctl.command = item_q.command;
	assign ctl.hit = hit;
	assign ctl.use_free = use_free;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkvc_cell #(
			.RANK_W(RANK_W),
			.OCC_W(OCC_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.key(item_q.key),
			.value(item_q.value),
			.hit_rank(hit_rank),
			.occ_m1(occ_m1),
			.free_in(free_chain[i]),
			.free_out(free_chain[i+1]),
			.hit_in(hit_chain[i]),
			.hit_out(hit_chain[i+1]),
			.data_in(data_chain[i]),
			.data_out(data_chain[i+1]),
			.rank_in(rank_chain[i]),
			.rank_out(rank_chain[i+1])
		);
	end

	always_comb begin
		if (item_q.command == lkvc_pkg::CMD_PUT) begin
			read_data = '0;
		end else if (hit) begin
			read_data = hit_data;
		end else begin
			read_data = lkvc_pkg::MISS_DATA;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_q <= in_data;
		end
		if (upd_go) begin
			out_q.hit <= hit;
			out_q.read_data <= read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			capacity_q <= lkvc_pkg::CAP_RESET;
			occ_q <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (upd_go) begin
				out_valid_q <= 1'b1;
				if ((item_q.command == lkvc_pkg::CMD_PUT) && !hit && use_free) begin
					occ_q <= OCC_W'(occ_q + 1'b1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

@@ sim/lkvc_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_scoreboard: result checker for the LRU key-value cache
// Watches the configuration port and both beat channels. It keeps its own
// copy of the entry table and the capacity register, works out the result of
// every accepted input beat and compares each output beat, field by field,
// with the oldest result still owed.
// ----------------------------------------------------------------------------
module lkvc_scoreboard #(
	parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lkvc_pkg::CAP_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input lkvc_pkg::lkvc_in_t in_data,
	input logic out_valid,
	input logic out_stall,
	input lkvc_pkg::lkvc_out_t out_data,
	output int errors,
	output int outstanding,
	output int beats_out,
	output int hits,
	output int evictions
);

	logic [lkvc_pkg::KEY_W-1:0] slot_key [ENTRIES];
	logic [lkvc_pkg::DATA_W-1:0] slot_value [ENTRIES];
	logic slot_live [ENTRIES];
	int slot_age [ENTRIES];
	int live_count;
	logic [lkvc_pkg::CAP_W-1:0] capacity;
	lkvc_pkg::lkvc_out_t owed_results [$];

	task automatic report_mismatch(input string what,
			input logic [lkvc_pkg::DATA_W-1:0] got,
			input logic [lkvc_pkg::DATA_W-1:0] want);
		$display("ERROR: result beat %0d, %s: got %h, expected %h", beats_out, what, got, want);
		errors++;
	endtask

	task automatic make_recent(input int s);
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot_live[i] && i != s && slot_age[i] < slot_age[s]) begin
				slot_age[i]++;
			end
		end
		slot_age[s] = 0;
	endtask

	task automatic cache_access(input lkvc_pkg::lkvc_in_t beat,
			output lkvc_pkg::lkvc_out_t res);
		int i;
		int found;
		int slot;
		int limit;
		int oldest;
		found = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (found < 0 && slot_live[i] && slot_key[i] == beat.key) begin
				found = i;
			end
		end
		res.hit = (found >= 0);
		if (beat.command == lkvc_pkg::CMD_GET) begin
			if (found >= 0) begin
				res.read_data = slot_value[found];
				make_recent(found);
			end else begin
				res.read_data = lkvc_pkg::MISS_DATA;
			end
		end else begin
			res.read_data = '0;
			if (found >= 0) begin
				slot_value[found] = beat.value;
				make_recent(found);
			end else begin
				limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
				slot = -1;
				if (live_count < limit) begin
					for (i = 0; i < ENTRIES; i++) begin
						if (slot < 0 && !slot_live[i]) begin
							slot = i;
						end
					end
				end
				if (slot < 0) begin
					// The least recent entry gives up its slot; the first one wins a tie.
					oldest = 0;
					for (i = 0; i < ENTRIES; i++) begin
						if (slot_live[i] && (slot < 0 || slot_age[i] > oldest)) begin
							oldest = slot_age[i];
							slot = i;
						end
					end
					if (slot < 0) begin
						slot = 0;
					end
					slot_live[slot] = 1'b0;
					if (live_count > 0) begin
						live_count--;
					end
					evictions++;
				end
				for (i = 0; i < ENTRIES; i++) begin
					if (slot_live[i]) begin
						slot_age[i]++;
					end
				end
				slot_key[slot] = beat.key;
				slot_value[slot] = beat.value;
				slot_live[slot] = 1'b1;
				slot_age[slot] = 0;
				live_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int i;
		lkvc_pkg::lkvc_out_t want;
		if (!arst_n) begin
			for (i = 0; i < ENTRIES; i++) begin
				slot_key[i] = '0;
				slot_value[i] = '0;
				slot_live[i] = 1'b0;
				slot_age[i] = 0;
			end
			live_count = 0;
			capacity = lkvc_pkg::CAP_RESET;
			owed_results.delete();
			errors = 0;
			beats_out = 0;
			hits = 0;
			evictions = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				capacity = cfg_data;
			end
			if (out_valid && !out_stall) begin
				beats_out++;
				if (owed_results.size() == 0) begin
					report_mismatch("no result was owed", out_data.read_data, '0);
				end else begin
					want = owed_results.pop_front();
					if (want.hit) begin
						hits++;
					end
					if (out_data.hit !== want.hit) begin
						report_mismatch("hit", out_data.hit, want.hit);
					end
					if (out_data.read_data !== want.read_data) begin
						report_mismatch("read_data", out_data.read_data, want.read_data);
					end
				end
			end
			if (in_valid && !in_stall) begin
				cache_access(in_data, want);
				owed_results.push_back(want);
			end
			outstanding <= owed_results.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the LRU key-value cache
// A directed opening covers misses, hits, updates, extreme keys and values
// and capacity settings below occupancy and at zero. Random phases then mix
// gets and puts over small key pools under several capacities, some above
// the table size, and idling patterns while the scoreboard checks every beat.
// ----------------------------------------------------------------------------
module tb_top;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	localparam int CLOCK_LIMIT = 200000;
	localparam int PHASES = 10;
	localparam int PHASE_BEATS = 120;
	localparam int POOL_MAX = 24;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [lkvc_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [lkvc_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
	localparam logic [lkvc_pkg::KEY_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	lkvc_pkg::lkvc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lkvc_pkg::lkvc_out_t out_data;

	idle_mode_e idle_mode = IDLE_NONE;
	int unsigned cycle_count = 0;
	int errors;
	int outstanding;
	int beats_out;
	int hits;
	int evictions;
	logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_MAX];
	int pool_n = 1;

	lru_key_value_cache #(
		.ENTRIES(lkvc_pkg::ENTRIES_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	lkvc_scoreboard #(
		.ENTRIES(lkvc_pkg::ENTRIES_DEF)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.errors(errors),
		.outstanding(outstanding),
		.beats_out(beats_out),
		.hits(hits),
		.evictions(evictions)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: out_stall <= ($urandom_range(0, 99) < 57);
			IDLE_BOTH: out_stall <= ($urandom_range(0, 99) < 23);
			default: out_stall <= 1'b0;
		endcase
	end

	task automatic push_beat(input logic cmd, input logic [lkvc_pkg::KEY_W-1:0] k,
			input logic [lkvc_pkg::DATA_W-1:0] v);
		int pct;
		lkvc_pkg::lkvc_in_t beat;
		case (idle_mode)
			IDLE_SEND: pct = 57;
			IDLE_BOTH: pct = 23;
			default: pct = 0;
		endcase
		while ($urandom_range(0, 99) < pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		beat.command = cmd;
		beat.key = k;
		beat.value = v;
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] cap);
		cfg_we <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [lkvc_pkg::CAP_W-1:0] caps [PHASES];
		int p;
		int j;
		int i;
		logic [lkvc_pkg::KEY_W-1:0] k;
		caps = '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_beat(lkvc_pkg::CMD_GET, 32'd0, 32'd0);
		push_beat(lkvc_pkg::CMD_PUT, KEY_MIN, KEY_MAX);
		push_beat(lkvc_pkg::CMD_PUT, KEY_MAX, KEY_MIN);
		push_beat(lkvc_pkg::CMD_PUT, 32'd0, 32'd0);
		push_beat(lkvc_pkg::CMD_PUT, ALL_ONES, ALL_ONES);
		push_beat(lkvc_pkg::CMD_GET, KEY_MIN, KEY_MAX);
		push_beat(lkvc_pkg::CMD_GET, KEY_MAX, 32'd0);
		push_beat(lkvc_pkg::CMD_GET, 32'd0, ALL_ONES);
		push_beat(lkvc_pkg::CMD_GET, ALL_ONES, KEY_MIN);
		push_beat(lkvc_pkg::CMD_PUT, KEY_MIN, 32'h5A5A_5A5A);
		push_beat(lkvc_pkg::CMD_GET, KEY_MIN, 32'd0);
		push_beat(lkvc_pkg::CMD_GET, 32'd1, 32'd0);
		drain();
		// Capacity below the current occupancy: each new key evicts exactly one entry.
		write_capacity(5'd2);
		push_beat(lkvc_pkg::CMD_PUT, 32'd100, 32'd1);
		push_beat(lkvc_pkg::CMD_PUT, 32'd101, 32'd2);
		push_beat(lkvc_pkg::CMD_GET, 32'd0, 32'd0);
		push_beat(lkvc_pkg::CMD_GET, KEY_MIN, 32'd0);
		drain();
		write_capacity(5'd0);
		push_beat(lkvc_pkg::CMD_PUT, 32'd200, 32'hA5A5_A5A5);
		push_beat(lkvc_pkg::CMD_GET, 32'd200, 32'd0);
		push_beat(lkvc_pkg::CMD_GET, 32'd101, 32'd0);

		for (p = 0; p < PHASES; p++) begin
			drain();
			idle_mode <= idle_mode_e'(p % 4);
			write_capacity(caps[p]);
			pool_n = ((caps[p] == 0) ? 1 : ((caps[p] > lkvc_pkg::ENTRIES_DEF) ?
				lkvc_pkg::ENTRIES_DEF : caps[p])) + 4;
			for (i = 0; i < pool_n; i++) begin
				key_pool[i] = $urandom;
			end
			if ($urandom_range(0, 1)) begin
				key_pool[0] = KEY_MIN;
			end
			if ($urandom_range(0, 1)) begin
				key_pool[1] = KEY_MAX;
			end
			for (j = 0; j < PHASE_BEATS; j++) begin
				if (p == 4 && j == PHASE_BEATS / 2) begin
					drain();
				end
				k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
				push_beat(1'($urandom_range(0, 1)), k, $urandom);
			end
		end
		drain();

		$display("Run checked %0d result beats with %0d hits and %0d evictions,",
			beats_out, hits, evictions);
		$display("across %0d capacity settings and four idling patterns.", PHASES + 3);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		while (cycle_count < CLOCK_LIMIT) begin
			@(posedge clk);
		end
		$display("ERROR: run exceeded %0d cycles", CLOCK_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
